@@ design/gradient_noise_3d_defines.svh @@
// Assertion macros used by the design file gn3d_back.sv
`ifndef GRADIENT_NOISE_3D_DEFINES_SVH
`define GRADIENT_NOISE_3D_DEFINES_SVH

`define GN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define GN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gn3d_pkg.sv @@
`default_nettype none
package gn3d_pkg;

    localparam int CoordW = 32;
    localparam int OutW   = 18;

    function automatic logic [7:0] perm(input logic [7:0] idx);
        logic [7:0] r;
        unique case (idx)
            8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
            8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
            8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
            8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
            8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
            8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
            8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
            8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
            8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
            8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
            8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
            8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
            8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
            8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
            8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
            8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
            8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
            8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
            8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
            8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
            8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
            8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
            8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
            8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
            8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
            8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
            8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
            8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
            8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
            8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
            8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
            8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
            8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
            8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
            8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
            8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
            8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
            8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
            8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
            8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
            8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
            8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
            8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
            8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
            8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
            8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
            8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
            8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
            8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
            8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
            8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
            8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
            8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
            8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
            8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
            8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
            8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
            8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
            8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
            8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
            8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
            8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
            8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
            8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic [7:0] h000;
        logic [7:0] h100;
        logic [7:0] h010;
        logic [7:0] h110;
        logic [7:0] h001;
        logic [7:0] h101;
        logic [7:0] h011;
        logic [7:0] h111;
    } corner_hash_t;

endpackage
`default_nettype wire

@@ design/gn3d_front.sv @@
`default_nettype none
module gn3d_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [gn3d_pkg::CoordW-1:0] coord_x,
    input  wire logic [gn3d_pkg::CoordW-1:0] coord_y,
    input  wire logic [gn3d_pkg::CoordW-1:0] coord_z,
    output logic                           out_valid,
    output gn3d_pkg::corner_hash_t         hash,
    output logic [FRAC_BITS-1:0]           fx,
    output logic [FRAC_BITS-1:0]           fy,
    output logic [FRAC_BITS-1:0]           fz
);
    logic                  v1_reg, v2_reg, v3_reg;
    logic [7:0]            zi1_reg, a_reg, b_reg;
    logic [7:0]            aa_reg, ab_reg, ba_reg, bb_reg;
    logic [FRAC_BITS-1:0]  fx1_reg, fy1_reg, fz1_reg, fx2_reg, fy2_reg, fz2_reg;
    logic [FRAC_BITS-1:0]  fx3_reg, fy3_reg, fz3_reg;
    gn3d_pkg::corner_hash_t hash_reg;
    logic [7:0]            xi, pa, pb;

    assign xi = coord_x[FRAC_BITS +: 8];
    assign pa = gn3d_pkg::perm(xi);
    assign pb = gn3d_pkg::perm(xi + 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= pa + coord_y[FRAC_BITS +: 8];
        b_reg   <= pb + coord_y[FRAC_BITS +: 8];
        zi1_reg <= coord_z[FRAC_BITS +: 8];
        fx1_reg <= coord_x[FRAC_BITS-1:0];
        fy1_reg <= coord_y[FRAC_BITS-1:0];
        fz1_reg <= coord_z[FRAC_BITS-1:0];
        aa_reg  <= gn3d_pkg::perm(a_reg) + zi1_reg;
        ab_reg  <= gn3d_pkg::perm(a_reg + 8'd1) + zi1_reg;
        ba_reg  <= gn3d_pkg::perm(b_reg) + zi1_reg;
        bb_reg  <= gn3d_pkg::perm(b_reg + 8'd1) + zi1_reg;
        fx2_reg <= fx1_reg;
        fy2_reg <= fy1_reg;
        fz2_reg <= fz1_reg;
        hash_reg.h000 <= gn3d_pkg::perm(aa_reg);
        hash_reg.h100 <= gn3d_pkg::perm(ba_reg);
        hash_reg.h010 <= gn3d_pkg::perm(ab_reg);
        hash_reg.h110 <= gn3d_pkg::perm(bb_reg);
        hash_reg.h001 <= gn3d_pkg::perm(aa_reg + 8'd1);
        hash_reg.h101 <= gn3d_pkg::perm(ba_reg + 8'd1);
        hash_reg.h011 <= gn3d_pkg::perm(ab_reg + 8'd1);
        hash_reg.h111 <= gn3d_pkg::perm(bb_reg + 8'd1);
        fx3_reg <= fx2_reg;
        fy3_reg <= fy2_reg;
        fz3_reg <= fz2_reg;
    end

    assign out_valid = v3_reg;
    assign hash      = hash_reg;
    assign fx        = fx3_reg;
    assign fy        = fy3_reg;
    assign fz        = fz3_reg;
endmodule
`default_nettype wire

@@ design/gn3d_back.sv @@
`default_nettype none
`include "gradient_noise_3d_defines.svh"
module gn3d_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire gn3d_pkg::corner_hash_t   hash,
    input  wire logic [FRAC_BITS-1:0]     fx,
    input  wire logic [FRAC_BITS-1:0]     fy,
    input  wire logic [FRAC_BITS-1:0]     fz,
    output logic                          out_valid,
    output logic [gn3d_pkg::OutW-1:0]     noise_value
);
    localparam int VW = FRAC_BITS + 5;
    localparam int PW = 2 * VW;
    localparam int NS = 9;
    localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;

    function automatic logic signed [VW-1:0] gdot(input logic [7:0] hv,
        input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
        input logic signed [VW-1:0] z);
        logic [3:0] h;
        logic signed [VW-1:0] u, v;
        h = hv[3:0];
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return ((h[0]) ? -u : u) + ((h[1]) ? -v : v);
    endfunction

    function automatic logic signed [VW-1:0] mshr(input logic signed [VW-1:0] t,
        input logic signed [VW-1:0] p);
        logic signed [PW-1:0] m;
        m = PW'(t) * PW'(p);
        return VW'(m >>> FRAC_BITS);
    endfunction

    logic [NS-1:0]               v_reg;
    logic signed [VW-1:0]        tx_reg [4], ty_reg [4], tz_reg [4];
    logic signed [VW-1:0]        px_reg [5], py_reg [5], pz_reg [5];
    logic signed [VW-1:0]        d_reg [8];
    logic signed [VW-1:0]        l1_reg [4];
    logic signed [VW-1:0]        l2_reg [2];
    logic signed [VW-1:0]        r_reg;
    logic [gn3d_pkg::OutW-1:0]   out_reg;
    logic signed [VW+16:0]       rs;
    logic signed [VW-1:0]        x0, y0, z0, x1, y1, z1;

    assign x0 = VW'(fx);
    assign y0 = VW'(fy);
    assign z0 = VW'(fz);
    assign x1 = x0 - ONE;
    assign y1 = y0 - ONE;
    assign z1 = z0 - ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        tx_reg[0] <= x0;
        ty_reg[0] <= y0;
        tz_reg[0] <= z0;
        for (int i = 1; i < 4; i++)
        begin
            tx_reg[i] <= tx_reg[i-1];
            ty_reg[i] <= ty_reg[i-1];
            tz_reg[i] <= tz_reg[i-1];
        end
        px_reg[0] <= VW'(x0 * 6 - 15 * ONE);
        py_reg[0] <= VW'(y0 * 6 - 15 * ONE);
        pz_reg[0] <= VW'(z0 * 6 - 15 * ONE);
        px_reg[1] <= VW'(mshr(tx_reg[0], px_reg[0]) + 10 * ONE);
        py_reg[1] <= VW'(mshr(ty_reg[0], py_reg[0]) + 10 * ONE);
        pz_reg[1] <= VW'(mshr(tz_reg[0], pz_reg[0]) + 10 * ONE);
        for (int i = 2; i < 5; i++)
        begin
            px_reg[i] <= mshr(tx_reg[i-1], px_reg[i-1]);
            py_reg[i] <= mshr(ty_reg[i-1], py_reg[i-1]);
            pz_reg[i] <= mshr(tz_reg[i-1], pz_reg[i-1]);
        end
        d_reg[0] <= gdot(hash.h000, x0, y0, z0);
        d_reg[1] <= gdot(hash.h100, x1, y0, z0);
        d_reg[2] <= gdot(hash.h010, x0, y1, z0);
        d_reg[3] <= gdot(hash.h110, x1, y1, z0);
        d_reg[4] <= gdot(hash.h001, x0, y0, z1);
        d_reg[5] <= gdot(hash.h101, x1, y0, z1);
        d_reg[6] <= gdot(hash.h011, x0, y1, z1);
        d_reg[7] <= gdot(hash.h111, x1, y1, z1);
    end

    // dot products wait for the fades; fades ready after stage 5
    logic signed [VW-1:0] dq_reg [4][8];
    always_ff @(posedge clk)
    begin
        dq_reg[0] <= d_reg;
        for (int i = 1; i < 4; i++)
            dq_reg[i] <= dq_reg[i-1];
        for (int i = 0; i < 4; i++)
            l1_reg[i] <= dq_reg[3][2*i] + mshr(px_reg[4], dq_reg[3][2*i+1] - dq_reg[3][2*i]);
    end

    logic signed [VW-1:0] fv_reg, fw_reg [2];
    always_ff @(posedge clk)
    begin
        fv_reg    <= py_reg[4];
        fw_reg[0] <= pz_reg[4];
        fw_reg[1] <= fw_reg[0];
        for (int i = 0; i < 2; i++)
            l2_reg[i] <= l1_reg[2*i] + mshr(fv_reg, l1_reg[2*i+1] - l1_reg[2*i]);
        r_reg <= l2_reg[0] + mshr(fw_reg[1], l2_reg[1] - l2_reg[0]);
    end

    always_comb
    begin
        if (FRAC_BITS >= 16)
            rs = (VW+17)'(r_reg >>> (FRAC_BITS - 16));
        else
            rs = (VW+17)'(r_reg) <<< (16 - FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (rs > 131071)
            out_reg <= 18'h1FFFF;
        else if (rs < -131072)
            out_reg <= 18'h20000;
        else
            out_reg <= rs[gn3d_pkg::OutW-1:0];
    end

    assign out_valid   = v_reg[NS-1];
    assign noise_value = out_reg;

    `GN_ASSERT_NEXT(a_shift, clk, rst_n, in_valid, v_reg[0], "valid pipe lost a word")
    `GN_ASSERT_NEXT(a_keep, clk, rst_n, v_reg[5], v_reg[6], "valid pipe dropped mid-way")
    `GN_ASSERT_IMP(a_known, clk, rst_n, out_valid, !$isunknown(noise_value), "unknown word")
endmodule
`default_nettype wire

@@ design/gradient_noise_3d.sv @@
`default_nettype none
// 3D improved gradient noise, Q15.16 coordinates in, Q1.16 saturated value out.
// A point is taken with start whenever busy is low; busy is always low, so one
// point enters every cycle. The value appears on noise_value with done high for
// one cycle, once the point has passed the chained permutation ROM lookups, then
// the fade multiplier chain and the three blend levels, one multiplier per stage.
// The receiver cannot stall the result.
module gradient_noise_3d #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [31:0]  coord_x,
    input  wire logic [31:0]  coord_y,
    input  wire logic [31:0]  coord_z,
    output logic              done,
    output logic [17:0]       noise_value
);
    logic                   fv;
    gn3d_pkg::corner_hash_t hash;
    logic [FRAC_BITS-1:0]   fx, fy, fz;

    assign busy = 1'b0;

    gn3d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(fv), .hash(hash), .fx(fx), .fy(fy), .fz(fz)
    );

    gn3d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(fv), .hash(hash),
        .fx(fx), .fy(fy), .fz(fz), .out_valid(done), .noise_value(noise_value)
    );
endmodule
`default_nettype wire
